[hdl/arm_branch_relocation_patcher_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the relocation patcher
// Clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARM_BRANCH_RELOCATION_PATCHER_TOP_ASSERT_SVH
`define ARM_BRANCH_RELOCATION_PATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define ABRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// delayed implication, consequent later than the antecedent
`define ABRP_ASSERT_LAT2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> ##1 (cons)) \
        else $error(msg);

`endif

[hdl/abrp_pkg.sv]
// ----------------------------------------------------------------------------
// abrp_pkg
// Relocation type numbers, status codes and field widths of the patcher.
// ----------------------------------------------------------------------------
package abrp_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned TypeW   = 8;
    localparam int unsigned StatusW = 4;

    localparam logic [TypeW-1:0] TYPE_ABS32    = 8'd2;
    localparam logic [TypeW-1:0] TYPE_THM_CALL = 8'd10;
    localparam logic [TypeW-1:0] TYPE_CALL     = 8'd28;
    localparam logic [TypeW-1:0] TYPE_JUMP24   = 8'd29;
    localparam logic [TypeW-1:0] TYPE_TARGET1  = 8'd38;

    localparam logic [3:0]  COND_ALWAYS   = 4'hE;
    localparam logic [15:0] THM_BLX_LOW   = 16'hE800;
    localparam logic [7:0]  ARM_BLX_OPHI  = 8'hFA;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 4'd0,
        ST_UNKNOWN   = 4'd1,
        ST_HALF      = 4'd2,
        ST_WORD      = 4'd3,
        ST_T2A_STUB  = 4'd4,
        ST_A2T_STUB  = 4'd5,
        ST_J24_THUMB = 4'd6,
        ST_COND_BLX  = 4'd7,
        ST_RANGE     = 4'd8
    } t_status;

    typedef struct packed {
        logic [TypeW-1:0] reloc_type;
        logic [WordW-1:0] orig_word;
        logic [WordW-1:0] symbol_address;
        logic [WordW-1:0] place_offset;
        logic             target_is_thumb;
    } t_request;

endpackage

[hdl/abrp_calc.sv]
// ----------------------------------------------------------------------------
// abrp_calc
// Combinational patch logic: displacement, field re-encoding and checks.
// ----------------------------------------------------------------------------
module abrp_calc (
    input  abrp_pkg::t_request         i_req,
    input  logic                       i_interworking,
    output logic [abrp_pkg::WordW-1:0] o_patched_word,
    output abrp_pkg::t_status          o_status
);
    import abrp_pkg::*;

    logic [WordW-1:0] w, s, p;
    logic             t;
    logic [WordW-1:0] thm_addend, arm_addend;
    logic [WordW-1:0] thm_disp, arm_disp;
    logic             thm_in_range, arm_in_range;
    logic [15:0]      thm_hi, thm_lo;
    logic [WordW-1:0] arm_res;
    logic [WordW-1:0] res;
    t_status          st;

    assign w = i_req.orig_word;
    assign s = i_req.symbol_address;
    assign p = i_req.place_offset;
    assign t = i_req.target_is_thumb;

    // Thumb pair: 22-bit field, halfword units, sign from the top of the first half
    assign thm_addend = {{9{w[10]}}, w[10:0], w[26:16], 1'b0};
    // ARM branch: 24-bit field, word units
    assign arm_addend = {{6{w[23]}}, w[23:0], 2'b00};

    assign thm_disp = s + thm_addend - p;
    assign arm_disp = s + arm_addend - p;

    // magnitude strictly below the limit; the most negative value is out
    assign thm_in_range = thm_disp[31]
        ? ((&thm_disp[31:22]) && (|thm_disp[21:0]))
        : ~(|thm_disp[31:22]);
    assign arm_in_range = arm_disp[31]
        ? ((&arm_disp[31:25]) && (|arm_disp[24:0]))
        : ~(|arm_disp[31:25]);

    assign thm_hi = {w[15:11], thm_disp[22:12]};
    assign thm_lo = t ? {w[31:27], thm_disp[11:1]}
                      : (THM_BLX_LOW | {5'd0, thm_disp[11:1]});

    // unconditional BL to Thumb becomes BLX, half-word bit in H
    assign arm_res = t ? {ARM_BLX_OPHI[7:1], arm_disp[1], arm_disp[25:2]}
                       : {w[31:24], arm_disp[25:2]};

    always_comb begin
        res = '0;
        st  = ST_OK;
        case (i_req.reloc_type)
            TYPE_ABS32, TYPE_TARGET1: begin
                res = (w + s) | {{(WordW-1){1'b0}}, t};
            end
            TYPE_THM_CALL: begin
                if (t && s[0])                     st = ST_HALF;
                else if (!t && !i_interworking)    st = ST_T2A_STUB;
                else if (!t && (|s[1:0]))          st = ST_WORD;
                else if (!thm_in_range)            st = ST_RANGE;
                else                               res = {thm_lo, thm_hi};
            end
            TYPE_CALL, TYPE_JUMP24: begin
                if (t && s[0])                             st = ST_HALF;
                else if (t && i_req.reloc_type == TYPE_JUMP24) st = ST_J24_THUMB;
                else if (t && !i_interworking)             st = ST_A2T_STUB;
                else if (t && w[31:28] != COND_ALWAYS)     st = ST_COND_BLX;
                else if (!t && (|s[1:0]))                  st = ST_WORD;
                else if (!arm_in_range)                    st = ST_RANGE;
                else                                       res = arm_res;
            end
            default: begin
                st = ST_UNKNOWN;
            end
        endcase
    end

    // drop the word on any error
    assign o_patched_word = (st == ST_OK) ? res : '0;
    assign o_status       = st;

endmodule

[hdl/arm_branch_relocation_patcher_top.sv]
// ----------------------------------------------------------------------------
// arm_branch_relocation_patcher_top
// Patches ABS32/TARGET1, THM_CALL and CALL/JUMP24 relocation words.
//
//   channel   | direction | handshake               | beat
//   ----------+-----------+-------------------------+---------------------------
//   request   | in        | start high, busy low    | type, word, S, P, thumb
//   result    | out       | o_done strobe, 1 cycle  | patched word, address, status
//   config    | in        | i_cfg_valid/o_cfg_ready | interworking_allowed
//
// One request per cycle; each request passes the input register, then the result
// register around the patch logic, and the result beat is presented with o_done
// when it leaves the result register.
// busy stays low and o_cfg_ready stays high: nothing in the path iterates.
// i_rst_n is synchronous: it clears both valid flags and the interworking bit.
// The receiver cannot stall, so results leave in request order with no queue.
// ----------------------------------------------------------------------------
module arm_branch_relocation_patcher_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [abrp_pkg::TypeW-1:0]   i_reloc_type,
    input  logic [abrp_pkg::WordW-1:0]   i_orig_word,
    input  logic [abrp_pkg::WordW-1:0]   i_symbol_address,
    input  logic [abrp_pkg::WordW-1:0]   i_place_offset,
    input  logic                         i_target_is_thumb,
    output logic                         o_done,
    output logic [abrp_pkg::WordW-1:0]   o_patched_word,
    output logic [abrp_pkg::WordW-1:0]   o_write_address,
    output logic [abrp_pkg::StatusW-1:0] o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);
    import abrp_pkg::*;

    logic             r_interworking;
    logic             r_in_valid;
    t_request         r_req;
    logic             r_out_valid;
    logic [WordW-1:0] r_out_word;
    logic [WordW-1:0] r_out_addr;
    t_status          r_out_status;
    logic [WordW-1:0] n_out_word;
    t_status          n_out_status;
    logic             accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interworking <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_interworking <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.reloc_type      <= i_reloc_type;
            r_req.orig_word       <= i_orig_word;
            r_req.symbol_address  <= i_symbol_address;
            r_req.place_offset    <= i_place_offset;
            r_req.target_is_thumb <= i_target_is_thumb;
        end
    end

    abrp_calc u_calc (
        .i_req          (r_req),
        .i_interworking (r_interworking),
        .o_patched_word (n_out_word),
        .o_status       (n_out_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_word   <= n_out_word;
            r_out_addr   <= r_req.place_offset;
            r_out_status <= n_out_status;
        end
    end

    assign o_done          = r_out_valid;
    assign o_patched_word  = r_out_word;
    assign o_write_address = r_out_addr;
    assign o_status        = r_out_status;

endmodule

[hdl/abrp_checker.sv]
// ----------------------------------------------------------------------------
// abrp_checker
// Port-level checks on the relocation patcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "arm_branch_relocation_patcher_top_assert.svh"

module abrp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [abrp_pkg::WordW-1:0]   i_place_offset,
    input logic                         o_done,
    input logic [abrp_pkg::WordW-1:0]   o_patched_word,
    input logic [abrp_pkg::WordW-1:0]   o_write_address,
    input logic [abrp_pkg::StatusW-1:0] o_status
);
    import abrp_pkg::*;

    logic accept_beat;
    logic error_beat;

    assign accept_beat = start && !busy;
    assign error_beat  = o_done && (o_status != ST_OK);

    // every accepted beat yields one result
    `ABRP_ASSERT_LAT2(a_accept_gives_result, accept_beat, o_done, "accept gave no result")

    // a result only follows an accepted beat
    `ABRP_ASSERT_NOW(a_no_spurious_result, o_done, $past(accept_beat, 2), "result without request")

    // errored results carry a zero word
    `ABRP_ASSERT_NOW(a_error_word_zero, error_beat, o_patched_word == '0, "error with non-zero word")

    // address of a result is the place of the request that it answers
    `ABRP_ASSERT_NOW(a_write_address, o_done, o_write_address == $past(i_place_offset, 2), "bad address")

endmodule

bind arm_branch_relocation_patcher_top abrp_checker u_abrp_checker (.*);

[tb/arm_branch_relocation_patcher_top_tb.sv]
// ----------------------------------------------------------------------------
// arm_branch_relocation_patcher_top_tb
// Self-checking bench for the relocation patcher. Drives ABS32/TARGET1,
// THM_CALL, CALL/JUMP24 and unsupported requests, with interworking both
// off and on. Each accepted request is predicted here and checked in order
// against the result strobe.
// ----------------------------------------------------------------------------
module arm_branch_relocation_patcher_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import abrp_pkg::*;

    localparam int unsigned    CYCLE_LIMIT = 200000;
    localparam logic [7:0]     TYPE_V4BX   = 8'd40;
    localparam logic [31:0]    THM_REACH   = 32'h0040_0000;
    localparam logic [31:0]    ARM_REACH   = 32'h0200_0000;
    localparam logic [31:0]    DIR_PLACE   = 32'h0001_0000;
    localparam logic [31:0]    THM_BL_PAIR = 32'hF800_F000;
    localparam logic [31:0]    ARM_BL      = 32'hEB00_0000;

    typedef struct packed {
        logic [WordW-1:0] word;
        logic [WordW-1:0] addr;
        t_status          status;
    } t_patch;

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 start             = 1'b0;
    logic                 busy;
    logic [TypeW-1:0]     i_reloc_type      = '0;
    logic [WordW-1:0]     i_orig_word       = '0;
    logic [WordW-1:0]     i_symbol_address  = '0;
    logic [WordW-1:0]     i_place_offset    = '0;
    logic                 i_target_is_thumb = 1'b0;
    logic                 o_done;
    logic [WordW-1:0]     o_patched_word;
    logic [WordW-1:0]     o_write_address;
    logic [StatusW-1:0]   o_status;
    logic                 i_cfg_valid       = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_data        = 1'b0;

    t_patch      pending_patches[$];
    logic        interworking = 1'b0;
    int unsigned failures     = 0;
    int unsigned cycle_count  = 0;
    int unsigned sender_idle_pct = 0;

    arm_branch_relocation_patcher_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_reloc_type      (i_reloc_type),
        .i_orig_word       (i_orig_word),
        .i_symbol_address  (i_symbol_address),
        .i_place_offset    (i_place_offset),
        .i_target_is_thumb (i_target_is_thumb),
        .o_done            (o_done),
        .o_patched_word    (o_patched_word),
        .o_write_address   (o_write_address),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Addend held in the instruction's offset field, scaled and sign extended.
    function automatic logic [31:0] branch_addend(logic [7:0] rtype, logic [31:0] word);
        if (rtype == TYPE_THM_CALL)
            return {{9{word[10]}}, word[10:0], word[26:16], 1'b0};
        if (rtype == TYPE_CALL || rtype == TYPE_JUMP24)
            return {{6{word[23]}}, word[23:0], 2'b00};
        return '0;
    endfunction

    function automatic logic out_of_reach(logic [31:0] disp, logic [31:0] reach);
        logic [31:0] mag;
        mag = disp[31] ? -disp : disp;
        return mag >= reach;
    endfunction

    function automatic t_patch patch_reloc(t_request r, logic iw);
        t_patch      res;
        logic [31:0] disp;
        logic [15:0] first_half;
        logic [15:0] second_half;
        res.word   = '0;
        res.addr   = r.place_offset;
        res.status = ST_OK;
        disp = r.symbol_address + branch_addend(r.reloc_type, r.orig_word) - r.place_offset;
        case (r.reloc_type)
            TYPE_ABS32, TYPE_TARGET1: begin
                res.word = (r.orig_word + r.symbol_address) | {31'd0, r.target_is_thumb};
            end
            TYPE_THM_CALL: begin
                first_half  = r.orig_word[15:0] & 16'hF800;
                second_half = r.orig_word[31:16] & 16'hF800;
                if (r.target_is_thumb) begin
                    if (r.symbol_address[0]) res.status = ST_HALF;
                end else if (!iw) begin
                    res.status = ST_T2A_STUB;
                end else if (r.symbol_address[1:0] != 2'b00) begin
                    res.status = ST_WORD;
                end else begin
                    second_half = THM_BLX_LOW;
                end
                if (res.status == ST_OK && out_of_reach(disp, THM_REACH)) res.status = ST_RANGE;
                res.word = {second_half | {5'd0, disp[11:1]}, first_half | {5'd0, disp[22:12]}};
            end
            TYPE_CALL, TYPE_JUMP24: begin
                res.word = {r.orig_word[31:24], 24'd0};
                if (r.target_is_thumb) begin
                    if (r.symbol_address[0])               res.status = ST_HALF;
                    else if (r.reloc_type == TYPE_JUMP24)  res.status = ST_J24_THUMB;
                    else if (!iw)                          res.status = ST_A2T_STUB;
                    else if (r.orig_word[31:28] != COND_ALWAYS) res.status = ST_COND_BLX;
                    else res.word = {ARM_BLX_OPHI[7:1], disp[1], 24'd0};
                end else if (r.symbol_address[1:0] != 2'b00) begin
                    res.status = ST_WORD;
                end
                if (res.status == ST_OK && out_of_reach(disp, ARM_REACH)) res.status = ST_RANGE;
                res.word[23:0] = disp[25:2];
            end
            default: res.status = ST_UNKNOWN;
        endcase
        if (res.status != ST_OK) res.word = '0;
        return res;
    endfunction

    // Predict on the accept edge, then check any result beat on the same edge.
    always @(posedge i_clk) begin : track_results
        t_patch due;
        if (!i_rst_n) begin
            interworking <= 1'b0;
        end else begin
            if (start && !busy)
                pending_patches.push_back(patch_reloc({i_reloc_type, i_orig_word,
                    i_symbol_address, i_place_offset, i_target_is_thumb}, interworking));
            if (i_cfg_valid && o_cfg_ready) interworking <= i_cfg_data;
            if (o_done) begin
                if (pending_patches.size() == 0) begin
                    $error("result beat with no request outstanding, status %0d", o_status);
                    failures++;
                end else begin
                    due = pending_patches.pop_front();
                    if (o_patched_word !== due.word) begin
                        $error("patched_word: expected %h, got %h", due.word, o_patched_word);
                        failures++;
                    end
                    if (o_write_address !== due.addr) begin
                        $error("write_address: expected %h, got %h", due.addr, o_write_address);
                        failures++;
                    end
                    if (o_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, o_status);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("arm_branch_relocation_patcher_top_tb NOT OK");
            $finish;
        end
    end

    task automatic send_reloc(logic [7:0] rtype, logic [31:0] word, logic [31:0] sym,
                              logic [31:0] place, logic thumb);
        start             <= 1'b1;
        i_reloc_type      <= rtype;
        i_orig_word       <= word;
        i_symbol_address  <= sym;
        i_place_offset    <= place;
        i_target_is_thumb <= thumb;
        do @(posedge i_clk); while (busy);
        // hold start high unless this beat is followed by a gap
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_patches.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_interworking(logic iw);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= iw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_abs32_and_unknown();
        write_interworking(1'b0);
        sender_idle_pct = 23;
        send_reloc(TYPE_ABS32,   32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        send_reloc(TYPE_ABS32,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_reloc(TYPE_TARGET1, 32'h1234_5678, 32'h8000_0000, 32'h0000_1000, 1'b1);
        send_reloc(8'd0,         $urandom,      $urandom,      $urandom,      1'b0);
        send_reloc(8'hFF,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_reloc(TYPE_V4BX,    32'hE12F_FF1E, 32'h0000_2000, DIR_PLACE,     1'b0);
    endtask

    task automatic test_thumb_call();
        // Thumb target: reach limits either side, odd target, most negative reach
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, DIR_PLACE + 32'h003F_FFFE, DIR_PLACE, 1'b1);
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, DIR_PLACE + 32'd1,         DIR_PLACE, 1'b1);
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, DIR_PLACE + THM_REACH,     DIR_PLACE, 1'b1);
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, DIR_PLACE - THM_REACH,     DIR_PLACE, 1'b1);
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, 32'h0000_0000, 32'h8000_0000, 1'b1);
        send_reloc(TYPE_THM_CALL, 32'hFFFF_FFFF, DIR_PLACE, DIR_PLACE, 1'b1);
        // ARM target without interworking needs a stub
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, DIR_PLACE + 32'h100, DIR_PLACE, 1'b0);
        write_interworking(1'b1);
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, DIR_PLACE + 32'd2,         DIR_PLACE, 1'b0);
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, DIR_PLACE + 32'h100,       DIR_PLACE, 1'b0);
        send_reloc(TYPE_THM_CALL, THM_BL_PAIR, DIR_PLACE - 32'h003F_FFFC, DIR_PLACE, 1'b0);
    endtask

    task automatic test_arm_branch();
        // interworking is on from the Thumb call test
        send_reloc(TYPE_CALL,   ARM_BL,        DIR_PLACE + 32'h101, DIR_PLACE, 1'b1);
        send_reloc(TYPE_JUMP24, ARM_BL,        DIR_PLACE + 32'h100, DIR_PLACE, 1'b1);
        send_reloc(TYPE_CALL,   32'h0B00_0000, DIR_PLACE + 32'h100, DIR_PLACE, 1'b1);
        send_reloc(TYPE_CALL,   ARM_BL,        DIR_PLACE + 32'h102, DIR_PLACE, 1'b1);
        send_reloc(TYPE_CALL,   32'h0A00_0000, DIR_PLACE + 32'h01FF_FFFC, DIR_PLACE, 1'b0);
        send_reloc(TYPE_JUMP24, 32'hEA00_0000, DIR_PLACE + ARM_REACH, DIR_PLACE, 1'b0);
        send_reloc(TYPE_CALL,   ARM_BL,        DIR_PLACE + 32'd2, DIR_PLACE, 1'b0);
        send_reloc(TYPE_JUMP24, 32'hEAFF_FFFF, DIR_PLACE - 32'h01FF_FFF8, DIR_PLACE, 1'b0);
        write_interworking(1'b0);
        send_reloc(TYPE_CALL,   ARM_BL,        DIR_PLACE + 32'h100, DIR_PLACE, 1'b1);
        send_reloc(TYPE_JUMP24, ARM_BL,        DIR_PLACE + 32'h101, DIR_PLACE, 1'b1);
    endtask

    task automatic test_random_traffic(int unsigned idle_pct, logic iw, int count,
                                       bit pause_midway);
        logic [7:0]  rtype;
        logic [31:0] word;
        logic [31:0] sym;
        logic [31:0] place;
        logic [31:0] reach;
        logic [31:0] disp;
        logic        thumb;
        int          roll;
        write_interworking(iw);
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2) drain_results();
            roll  = $urandom_range(99);
            word  = $urandom;
            sym   = $urandom;
            place = $urandom;
            thumb = 1'($urandom_range(1));
            if (roll < 8) begin
                rtype = 8'($urandom_range(255));
            end else if (roll < 22) begin
                rtype = roll[0] ? TYPE_ABS32 : TYPE_TARGET1;
            end else begin
                if (roll < 58) begin
                    rtype = TYPE_THM_CALL;
                    reach = THM_REACH;
                end else begin
                    rtype = (roll % 3 == 0) ? TYPE_JUMP24 : TYPE_CALL;
                    reach = ARM_REACH;
                    if ($urandom_range(3) != 0) word[31:28] = COND_ALWAYS;
                end
                // aim the displacement: in reach, at the edge, anywhere, or short
                case ($urandom_range(3))
                    0:       disp = $urandom_range(reach - 1);
                    1:       disp = reach + $urandom_range(8) - 4;
                    2:       disp = $urandom;
                    default: disp = $urandom_range(255);
                endcase
                if ($urandom_range(1)) disp = -disp;
                sym = place + disp - branch_addend(rtype, word);
                if ($urandom_range(9) != 0) begin
                    if (thumb) sym[0] = 1'b0;
                    else       sym[1:0] = 2'b00;
                end
            end
            send_reloc(rtype, word, sym, place, thumb);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_abs32_and_unknown();
        test_thumb_call();
        test_arm_branch();
        test_random_traffic(23, 1'b1, 500, 1'b1);
        test_random_traffic(49, 1'b0, 500, 1'b0);
        test_random_traffic(0,  1'b1, 500, 1'b0);
        drain_results();
        if (failures == 0)
            $display("arm_branch_relocation_patcher_top_tb OK");
        else
            $display("arm_branch_relocation_patcher_top_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/abrp_pkg.sv
hdl/abrp_calc.sv
hdl/arm_branch_relocation_patcher_top.sv
hdl/abrp_checker.sv
tb/arm_branch_relocation_patcher_top_tb.sv
